// ===== design/cubic_bezier_midpoint_subdivider_defines.svh =====
// Assertion macros used by the subdivider datapath.
// No dependencies; clk and rst_n must be in scope where a macro is used.
`ifndef CUBIC_BEZIER_MIDPOINT_SUBDIVIDER_DEFINES_SVH
`define CUBIC_BEZIER_MIDPOINT_SUBDIVIDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBMS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cbms_pkg.sv =====
// Shared types and constants for the cubic Bezier midpoint subdivider.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cbms_pkg;

    localparam int NCOORD     = 12;
    localparam int LEVEL_W    = 3;
    localparam int OUT_W      = 32;
    localparam int INDEX_W    = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Word index of the depth register (byte address 0)
    localparam logic REG_IDX_DEPTH = 1'b0;

    localparam logic [LEVEL_W-1:0] DEPTH_RESET = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_NODE,
        ST_MID2,
        ST_MID3
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic emit_first;
        logic emit_end;
        logic stage1;
        logic stage2;
        logic push;
        logic pop;
    } dp_cmd_t;

    typedef struct packed {
        logic level_zero;
        logic stack_empty;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/cbms_ctrl.sv =====
// Controller state machine of the subdivider.
// Depends on cbms_pkg; drives the datapath through dp_cmd_t, reads dp_status_t.
`timescale 1ns / 1ps
`default_nettype none

module cbms_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cbms_pkg::dp_status_t status,
    output cbms_pkg::dp_cmd_t    cmd
);
    import cbms_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (status.out_free)
                begin
                    state_next = ST_NODE;
                end
            end
            ST_NODE:
            begin
                if (!status.level_zero)
                begin
                    state_next = ST_MID2;
                end
                else if (status.out_free && status.stack_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MID2:
            begin
                state_next = ST_MID3;
            end
            ST_MID3:
            begin
                state_next = ST_NODE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_FIRST:
            begin
                cmd.emit_first = status.out_free;
            end
            ST_NODE:
            begin
                if (!status.level_zero)
                begin
                    cmd.stage1 = 1'b1;
                end
                else if (status.out_free)
                begin
                    // leaf: emit its end point and resume the next pending half
                    cmd.emit_end = 1'b1;
                    cmd.pop      = !status.stack_empty;
                end
            end
            ST_MID2:
            begin
                cmd.stage2 = 1'b1;
            end
            ST_MID3:
            begin
                cmd.push = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/cbms_dp.sv =====
// Datapath of the subdivider: working segment, midpoint stages, segment stack,
// point counter and output register. Depends on cbms_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_bezier_midpoint_subdivider_defines.svh"

module cbms_dp #(
    parameter int MAX_DEPTH  = 5,
    parameter int COORD_BITS = 32
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  cbms_pkg::dp_cmd_t                                   cmd,
    output cbms_pkg::dp_status_t                                status,
    input  logic [cbms_pkg::LEVEL_W-1:0]                        run_depth,
    input  logic [cbms_pkg::NCOORD-1:0][COORD_BITS-1:0]         in_seg,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output logic signed [cbms_pkg::OUT_W-1:0]                   point_x,
    output logic signed [cbms_pkg::OUT_W-1:0]                   point_y,
    output logic signed [cbms_pkg::OUT_W-1:0]                   point_z,
    output logic [cbms_pkg::INDEX_W-1:0]                        point_index,
    output logic                                                last
);
    import cbms_pkg::*;

    localparam int STACK_AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SP_W     = $clog2(MAX_DEPTH + 1);
    localparam int CNT_W    = MAX_DEPTH + 1;

    typedef logic [NCOORD-1:0][COORD_BITS-1:0] seg_t;
    typedef logic [2:0][COORD_BITS-1:0]        vec3_t;

    // Floor of (a + b) / 2 on the full one-bit-wider sum
    function automatic logic [COORD_BITS-1:0] midpoint(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] sum;
        sum = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        return sum[COORD_BITS:1];
    endfunction

    // Raw coordinate bits, truncated or zero-extended to the output width
    function automatic logic [OUT_W-1:0] to_out(input logic [COORD_BITS-1:0] v);
        logic [COORD_BITS+OUT_W-1:0] ext;
        ext = {{OUT_W{1'b0}}, v};
        return ext[OUT_W-1:0];
    endfunction

    seg_t                     seg_reg;
    logic [LEVEL_W-1:0]       level_reg;
    logic [SP_W-1:0]          sp_reg;
    logic [CNT_W-1:0]         count_reg;
    vec3_t                    m1_reg, m2_reg, m3_reg;
    vec3_t                    m12_reg, m23_reg;
    vec3_t                    m1_next, m2_next, m3_next;
    vec3_t                    m12_next, m23_next;
    vec3_t                    cp;
    seg_t                     left_seg, right_seg;
    seg_t                     stack_mem [MAX_DEPTH];
    logic [LEVEL_W-1:0]       lev_mem   [MAX_DEPTH];

    logic                     out_valid_reg;
    logic [OUT_W-1:0]         point_x_reg, point_y_reg, point_z_reg;
    logic [INDEX_W-1:0]       point_index_reg;
    logic                     last_reg;

    logic [SP_W-1:0]          sp_dec;
    logic [STACK_AW-1:0]      push_idx, pop_idx;
    logic [LEVEL_W-1:0]       level_dec;
    logic                     emit;
    logic                     last_flag;
    vec3_t                    emit_pt;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            m1_next[a]  = midpoint(seg_reg[a],     seg_reg[3 + a]);
            m2_next[a]  = midpoint(seg_reg[3 + a], seg_reg[6 + a]);
            m3_next[a]  = midpoint(seg_reg[6 + a], seg_reg[9 + a]);
            m12_next[a] = midpoint(m1_reg[a], m2_reg[a]);
            m23_next[a] = midpoint(m2_reg[a], m3_reg[a]);
            cp[a]       = midpoint(m12_reg[a], m23_reg[a]);

            left_seg[a]      = seg_reg[a];
            left_seg[3 + a]  = m1_reg[a];
            left_seg[6 + a]  = m12_reg[a];
            left_seg[9 + a]  = cp[a];

            right_seg[a]     = cp[a];
            right_seg[3 + a] = m23_reg[a];
            right_seg[6 + a] = m3_reg[a];
            right_seg[9 + a] = seg_reg[9 + a];

            emit_pt[a] = cmd.emit_first ? seg_reg[a] : seg_reg[9 + a];
        end
    end

    assign sp_dec    = sp_reg - SP_W'(1);
    assign push_idx  = sp_reg[STACK_AW-1:0];
    assign pop_idx   = sp_dec[STACK_AW-1:0];
    assign level_dec = level_reg - LEVEL_W'(1);
    assign emit      = cmd.emit_first | cmd.emit_end;
    assign last_flag = (count_reg == (CNT_W'(1) << run_depth));

    // Fields in declaration order: level_zero, stack_empty, out_free
    assign status = {(level_reg == '0), (sp_reg == '0), (!out_valid_reg || out_ready)};

    // Midpoint stages
    always_ff @(posedge clk)
    begin
        if (cmd.stage1)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
        end
        if (cmd.stage2)
        begin
            m12_reg <= m12_next;
            m23_reg <= m23_next;
        end
    end

    // Segment stack write port: right half waits here
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[push_idx] <= right_seg;
            lev_mem[push_idx]   <= level_dec;
        end
    end

    // Working segment: load, descend into left half, or pop the stack
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seg_reg   <= in_seg;
            level_reg <= run_depth;
        end
        else if (cmd.push)
        begin
            seg_reg   <= left_seg;
            level_reg <= level_dec;
        end
        else if (cmd.pop)
        begin
            seg_reg   <= stack_mem[pop_idx];
            level_reg <= lev_mem[pop_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                sp_reg <= '0;
            end
            else if (cmd.push)
            begin
                sp_reg <= sp_reg + SP_W'(1);
            end
            else if (cmd.pop)
            begin
                sp_reg <= sp_dec;
            end

            if (cmd.load)
            begin
                count_reg <= '0;
            end
            else if (emit)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            point_x_reg     <= to_out(emit_pt[0]);
            point_y_reg     <= to_out(emit_pt[1]);
            point_z_reg     <= to_out(emit_pt[2]);
            point_index_reg <= INDEX_W'(count_reg);
            last_reg        <= last_flag;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_x     = $signed(point_x_reg);
    assign point_y     = $signed(point_y_reg);
    assign point_z     = $signed(point_z_reg);
    assign point_index = point_index_reg;
    assign last        = last_reg;

    `CBMS_ASSERT_SAME(a_sp_bound, 1'b1, sp_reg <= SP_W'(MAX_DEPTH), "segment stack overflow")
    `CBMS_ASSERT_SAME(a_no_overwrite, out_valid_reg && !out_ready, !emit, "held point overwritten")
    `CBMS_ASSERT_SAME(a_pop_nonempty, cmd.pop, sp_reg != '0, "pop from empty segment stack")
    `CBMS_ASSERT_SAME(a_last_drained, cmd.emit_end && last_flag, sp_reg == '0,
                      "last point emitted with segments pending")

endmodule

`default_nettype wire

// ===== design/cubic_bezier_midpoint_subdivider.sv =====
// Cubic Bezier subdivider top level: APB depth register, controller, datapath.
// Depends on cbms_pkg, cbms_ctrl and cbms_dp.
//
// One input transaction carries the four 3-D control points of a cubic Bezier
// curve (signed Q16.16 at the default width). The block splits the curve by de
// Casteljau midpoints depth times and returns 2^depth + 1 output transactions:
// the start point, every split point in order along the curve, and the end
// point, with point_index counting from zero and last set on the end point.
// Each midpoint is the full one-bit-wider sum shifted right, so it rounds
// toward negative infinity and never overflows. Depth comes from the register
// at byte address 0 (reset 3); values above MAX_DEPTH act as MAX_DEPTH, and
// depth zero yields just the two end points. Write depth only while idle.
// Order of work: the curve is taken, the start point is emitted, each split runs
// the midpoint tree (registered over three levels, with the right half pushed on
// the segment stack), and each leaf emits its end point and pops the next
// pending half from the stack; start and leaf points wait while the output
// register is full. in_ready is high only between curves; the final point may
// still sit in the output register while the next curve is taken. The segment
// stack holds MAX_DEPTH halves and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_midpoint_subdivider #(
    parameter int MAX_DEPTH  = 5,
    parameter int COORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [cbms_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [cbms_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [cbms_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready,
    // curve input
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_BITS-1:0]          p0_x,
    input  logic signed [COORD_BITS-1:0]          p0_y,
    input  logic signed [COORD_BITS-1:0]          p0_z,
    input  logic signed [COORD_BITS-1:0]          p1_x,
    input  logic signed [COORD_BITS-1:0]          p1_y,
    input  logic signed [COORD_BITS-1:0]          p1_z,
    input  logic signed [COORD_BITS-1:0]          p2_x,
    input  logic signed [COORD_BITS-1:0]          p2_y,
    input  logic signed [COORD_BITS-1:0]          p2_z,
    input  logic signed [COORD_BITS-1:0]          p3_x,
    input  logic signed [COORD_BITS-1:0]          p3_y,
    input  logic signed [COORD_BITS-1:0]          p3_z,
    // point output
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cbms_pkg::OUT_W-1:0]     point_x,
    output logic signed [cbms_pkg::OUT_W-1:0]     point_y,
    output logic signed [cbms_pkg::OUT_W-1:0]     point_z,
    output logic [cbms_pkg::INDEX_W-1:0]          point_index,
    output logic                                  last
);
    import cbms_pkg::*;

    logic [LEVEL_W-1:0]                 depth_reg;
    logic [LEVEL_W-1:0]                 run_depth;
    logic                               cfg_write;
    logic                               hit_depth;
    logic [NCOORD-1:0][COORD_BITS-1:0]  in_seg;
    dp_cmd_t                            cmd;
    dp_status_t                         status;

    // Register is selected by word index; byte offset bits are ignored
    assign hit_depth = (paddr[CFG_ADDR_W-1] == REG_IDX_DEPTH);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = hit_depth ? CFG_DATA_W'(depth_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
        end
        else if (cfg_write && hit_depth)
        begin
            depth_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    // Saturate the requested depth to what the stack can hold
    assign run_depth = (depth_reg > LEVEL_W'(MAX_DEPTH)) ? LEVEL_W'(MAX_DEPTH) : depth_reg;

    // Coordinate slots: p0 in 0..2, p1 in 3..5, p2 in 6..8, p3 in 9..11
    assign in_seg = {p3_z, p3_y, p3_x, p2_z, p2_y, p2_x,
                     p1_z, p1_y, p1_x, p0_z, p0_y, p0_x};

    cbms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cbms_dp #(
        .MAX_DEPTH  (MAX_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .run_depth   (run_depth),
        .in_seg      (in_seg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_index (point_index),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== tb/cbms_point_checker.sv =====
// Scoreboard for the cubic Bezier subdivider: watches the depth register, the curve
// input and the point output, predicts every point and compares. Depends on cbms_pkg.
`timescale 1ns / 1ps

module cbms_point_checker #(
    parameter int MAX_DEPTH = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [cbms_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [cbms_pkg::CFG_DATA_W-1:0]     pwdata,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p0_x,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p0_y,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p0_z,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p1_x,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p1_y,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p1_z,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p2_x,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p2_y,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p2_z,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p3_x,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p3_y,
    input  logic signed [cbms_pkg::OUT_W-1:0]   p3_z,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [cbms_pkg::OUT_W-1:0]   point_x,
    input  logic signed [cbms_pkg::OUT_W-1:0]   point_y,
    input  logic signed [cbms_pkg::OUT_W-1:0]   point_z,
    input  logic [cbms_pkg::INDEX_W-1:0]        point_index,
    input  logic                                last,
    output int                                  mismatches,
    output int                                  points_pending,
    output int                                  points_checked,
    output int                                  curves_taken
);

    import cbms_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } vec_t;

    typedef struct packed {
        vec_t p0;
        vec_t p1;
        vec_t p2;
        vec_t p3;
    } seg_t;

    typedef struct packed {
        vec_t               pos;
        logic [INDEX_W-1:0] index;
        logic               fin;
    } curve_point_t;

    curve_point_t       expected_points[$];
    curve_point_t       want;
    logic [LEVEL_W-1:0] depth_reg;
    seg_t               taken_curve;

    // Full one-bit-wider sum, shifted right: rounds toward negative infinity.
    function automatic logic signed [OUT_W-1:0] halve_sum(input logic signed [OUT_W-1:0] a,
                                                          input logic signed [OUT_W-1:0] b);
        logic [OUT_W:0] sum;
        sum = {a[OUT_W-1], a} + {b[OUT_W-1], b};
        return sum[OUT_W:1];
    endfunction

    function automatic vec_t midpoint(input vec_t a, input vec_t b);
        return {halve_sum(a.x, b.x), halve_sum(a.y, b.y), halve_sum(a.z, b.z)};
    endfunction

    function automatic curve_point_t on_curve(input vec_t pos, input int unsigned n,
                                              input int unsigned total);
        return {pos, n[INDEX_W-1:0], n + 1 == total};
    endfunction

    // Depth-first split with the left half worked first, as the block does.
    function automatic void predict_curve(input seg_t curve);
        seg_t        stack[0:MAX_DEPTH];
        int unsigned levels[0:MAX_DEPTH];
        int unsigned eff_depth;
        int unsigned total;
        int unsigned n;
        int unsigned sub;
        int          sp;
        seg_t        s;
        vec_t        m1, m2, m3, m12, m23, cp;
        eff_depth = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg;
        total = (1 << eff_depth) + 1;
        n = 0;
        expected_points.push_back(on_curve(curve.p0, n, total));
        n++;
        stack[0] = curve;
        levels[0] = eff_depth;
        sp = 1;
        while (sp > 0) begin
            sp--;
            s = stack[sp];
            if (levels[sp] == 0) begin
                expected_points.push_back(on_curve(s.p3, n, total));
                n++;
            end
            else begin
                m1 = midpoint(s.p0, s.p1);
                m2 = midpoint(s.p1, s.p2);
                m3 = midpoint(s.p2, s.p3);
                m12 = midpoint(m1, m2);
                m23 = midpoint(m2, m3);
                cp = midpoint(m12, m23);
                sub = levels[sp] - 1;
                stack[sp] = {cp, m23, m3, s.p3};
                levels[sp] = sub;
                stack[sp + 1] = {s.p0, m1, m12, cp};
                levels[sp + 1] = sub;
                sp += 2;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] exp_val,
                                   input logic [OUT_W-1:0] got_val);
        $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, exp_val, got_val);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        points_checked = 0;
        curves_taken = 0;
        points_pending = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            depth_reg = DEPTH_RESET;
            expected_points.delete();
            points_pending <= 0;
        end
        else begin
            // compare first: a point leaving now can't belong to a curve taken now
            if (out_valid && out_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("point with nothing pending, index", '0, point_index);
                end
                else begin
                    want = expected_points.pop_front();
                    points_checked++;
                    if (point_x !== want.pos.x)
                        report_mismatch("point_x", want.pos.x, point_x);
                    if (point_y !== want.pos.y)
                        report_mismatch("point_y", want.pos.y, point_y);
                    if (point_z !== want.pos.z)
                        report_mismatch("point_z", want.pos.z, point_z);
                    if (point_index !== want.index)
                        report_mismatch("point_index", want.index, point_index);
                    if (last !== want.fin)
                        report_mismatch("last", want.fin, last);
                end
            end
            if (in_valid && in_ready) begin
                taken_curve = {p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z};
                predict_curve(taken_curve);
                curves_taken++;
            end
            // writes to any other word are dropped
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_IDX_DEPTH)
                depth_reg = pwdata[LEVEL_W-1:0];
            points_pending <= expected_points.size();
        end
    end

endmodule

// ===== tb/cubic_bezier_midpoint_subdivider_tb.sv =====
// Top of the subdivider testbench: clock, reset, curve and register stimulus,
// output back-pressure and verdict. Depends on cbms_pkg, cbms_point_checker and the RTL.
`timescale 1ns / 1ps

module cubic_bezier_midpoint_subdivider_tb;

    import cbms_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int STALL_MAX       = 18;
    localparam int NUM_PHASES      = 10;
    // output stall that holds the block mid-curve so that it refuses the next curve
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_AT_FIRST   = 300;
    localparam int HOLD_AT_SECOND  = 2000;
    // slowest legal quiet stretch is the hold-off
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 10;

    localparam logic [CFG_ADDR_W-1:0] ADDR_DEPTH    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    localparam logic signed [OUT_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [OUT_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] Q_ONE     = 32'sh0001_0000;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [OUT_W-1:0] curve_in[0:11];
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic signed [OUT_W-1:0] point_z;
    logic [INDEX_W-1:0]      point_index;
    logic                    last;

    int mismatches;
    int points_pending;
    int points_checked;
    int curves_taken;

    // next curve to offer, filled by the stimulus before each send
    logic signed [OUT_W-1:0] staged[0:11];
    bit                      send_calm;
    bit                      recv_calm;
    int unsigned             points_received;
    int unsigned             quiet_cycles;
    int                      cfg_writes;
    int                      phase_depth[NUM_PHASES];
    int                      phase_items[NUM_PHASES];

    cubic_bezier_midpoint_subdivider u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .p0_x        (curve_in[0]),
        .p0_y        (curve_in[1]),
        .p0_z        (curve_in[2]),
        .p1_x        (curve_in[3]),
        .p1_y        (curve_in[4]),
        .p1_z        (curve_in[5]),
        .p2_x        (curve_in[6]),
        .p2_y        (curve_in[7]),
        .p2_z        (curve_in[8]),
        .p3_x        (curve_in[9]),
        .p3_y        (curve_in[10]),
        .p3_z        (curve_in[11]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_index (point_index),
        .last        (last)
    );

    cbms_point_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .p0_x           (curve_in[0]),
        .p0_y           (curve_in[1]),
        .p0_z           (curve_in[2]),
        .p1_x           (curve_in[3]),
        .p1_y           (curve_in[4]),
        .p1_z           (curve_in[5]),
        .p2_x           (curve_in[6]),
        .p2_y           (curve_in[7]),
        .p2_z           (curve_in[8]),
        .p3_x           (curve_in[9]),
        .p3_y           (curve_in[10]),
        .p3_z           (curve_in[11]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .point_index    (point_index),
        .last           (last),
        .mismatches     (mismatches),
        .points_pending (points_pending),
        .points_checked (points_checked),
        .curves_taken   (curves_taken)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // Mix of coordinate classes: full-range bit patterns, small values near zero,
    // the extremes and their neighbors, and moderate Q16.16 values.
    function automatic logic signed [OUT_W-1:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 2047) - 1024;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return COORD_MIN + 1;
                    3: return COORD_MAX - 1;
                    4: return -1;
                    default: return 0;
                endcase
            end
            2, 3: return $urandom;
            default: return ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    // Load one value per control point: x gets it, y its complement, z it again.
    task automatic stage_axes(input logic signed [OUT_W-1:0] a, input logic signed [OUT_W-1:0] b,
                              input logic signed [OUT_W-1:0] c, input logic signed [OUT_W-1:0] d);
        staged = '{a, ~a, a, b, ~b, b, c, ~c, c, d, ~d, d};
    endtask

    task automatic stage_random();
        int k;
        for (k = 0; k < 12; k++)
            staged[k] = rand_coord();
    endtask

    // Offer the staged curve after a random gap and hold it until the block takes it.
    // Valid stays high across back-to-back transactions; only the payload advances.
    task automatic send_curve();
        int unsigned gap;
        int          k;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        for (k = 0; k < 12; k++)
            curve_in[k] <= staged[k];
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid, wait for every predicted point to come back, then let the block settle.
    task automatic drain_points();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (points_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the access edge.
    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [2:0] depth_val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        // upper bits are don't-care for a 3-bit register; randomize them
        pwdata  <= ($urandom & ~32'h7) | depth_val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    // Receiver: random stall per point, calm stretches, and two long hold-offs that
    // back the block up until in_ready drops while the sender keeps offering curves.
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_calm = !recv_calm;
            if (points_received == HOLD_AT_FIRST || points_received == HOLD_AT_SECOND)
                stall = HOLD_OFF_CYCLES;
            else
                stall = recv_calm ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            points_received++;
        end
    end

    // Watchdog: any transaction on any port resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transaction for %0d cycles, %0d points pending",
                         $time, quiet_cycles, points_pending);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int p;
        int i;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        for (i = 0; i < 12; i++)
            curve_in[i] = '0;
        send_calm = 1'b0;
        recv_calm = 1'b0;
        points_received = 0;
        quiet_cycles = 0;
        cfg_writes = 0;
        // small depths carry most of the load; the slow ones get shorter phases
        phase_depth = '{1, 0, 2, 4, 6, 3, 5, 2, 7, 1};
        phase_items = '{50, 40, 50, 40, 20, 50, 20, 50, 20, 40};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed curves at the reset depth: zeros, both extremes, alternating
        // extremes (largest sums both ways), odd sums for negative rounding, a line, a MIN-to-MAX step.
        stage_axes(0, 0, 0, 0);
        send_curve();
        stage_axes(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_curve();
        stage_axes(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_curve();
        stage_axes(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        send_curve();
        stage_axes(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_curve();
        stage_axes(-1, 0, -1, 0);
        send_curve();
        stage_axes(1, 0, 1, 0);
        send_curve();
        stage_axes(-3, 2, -5, 4);
        send_curve();
        stage_axes(0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE);
        send_curve();
        stage_axes(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_curve();
        drain_points();

        // Depth zero: only the two end points come out.
        apb_write(ADDR_DEPTH, 3'd0);
        stage_axes(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        send_curve();
        stage_axes(-1, 0, -1, 0);
        send_curve();
        stage_random();
        send_curve();
        drain_points();

        // Depth seven saturates to the deepest split.
        apb_write(ADDR_DEPTH, 3'd7);
        stage_axes(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_curve();
        stage_random();
        send_curve();
        drain_points();

        // A write to an unmapped word must leave depth alone.
        apb_write(ADDR_UNMAPPED, 3'd1);
        stage_axes(-3, 2, -5, 4);
        send_curve();
        drain_points();

        apb_write(ADDR_DEPTH, 3'd5);
        stage_axes(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_curve();
        stage_random();
        send_curve();
        drain_points();

        // Random curves, one depth per phase, every setting 0..7 at least once.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            apb_write(ADDR_DEPTH, phase_depth[p][2:0]);
            for (i = 0; i < phase_items[p]; i++)
            begin
                stage_random();
                send_curve();
            end
            drain_points();
        end

        $display("Run covered %0d curves and %0d checked points", curves_taken, points_checked);
        $display("Depth writes: %0d (values 0..7, one unmapped word), long output hold-offs: 2",
                 cfg_writes);
        if (mismatches == 0 && points_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/cbms_pkg.sv
design/cbms_ctrl.sv
design/cbms_dp.sv
design/cubic_bezier_midpoint_subdivider.sv
tb/cbms_point_checker.sv
tb/cubic_bezier_midpoint_subdivider_tb.sv
